### src/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DFA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define DFA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define DFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DFA_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define DFA_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define DFA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### src/dfa_pkg.sv
// types and constants of the decimal float alu
package dfa_pkg;
   localparam int MANT_WIDTH_DEF = 16;
   localparam int EXP_WIDTH      = 16;
   localparam int RAW_WIDTH      = 32;
   localparam int ACTION_WIDTH   = 3;
   localparam int STATUS_WIDTH   = 2;
   localparam int EXP_INT_W      = 20;
   localparam int SQRT_BITS      = 16;
   localparam int ADD_MAX_GAP    = 14;
   localparam int DIV_REACH_LOG  = 24;
   localparam int SQRT_REACH_LOG = 20;
   localparam int ROUND_BIAS     = 5;
   localparam int RADIX          = 10;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_MAKE = 3'd0,
      ACT_MUL  = 3'd1,
      ACT_DIV  = 3'd2,
      ACT_ADD  = 3'd3,
      ACT_SUB  = 3'd4,
      ACT_SQRT = 3'd5
   } action_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STAT_OK       = 2'd0,
      STAT_DIV_ZERO = 2'd1,
      STAT_NEG_SQRT = 2'd2,
      STAT_EXP_OVF  = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ADD_SCALE,
      ST_ADD_SUM,
      ST_ADD_MAG,
      ST_DIV_SCALE,
      ST_DIV_WAIT,
      ST_SQ_SCALE,
      ST_SQ_ODD,
      ST_SQ_ITER,
      ST_SQ_HALF,
      ST_NORM_START,
      ST_NORM_WAIT,
      ST_FINISH
   } state_type;
endpackage

### src/dfa_chan_if.sv
// request and response channel interfaces
interface dfa_req_if #(parameter int MANT_WIDTH = dfa_pkg::MANT_WIDTH_DEF);
   logic                                   valid;
   logic                                   ready;
   logic [dfa_pkg::ACTION_WIDTH-1:0]       action;
   logic signed [dfa_pkg::RAW_WIDTH-1:0]   raw_mant;
   logic signed [MANT_WIDTH-1:0]           a_mant;
   logic signed [dfa_pkg::EXP_WIDTH-1:0]   a_exp;
   logic signed [MANT_WIDTH-1:0]           b_mant;
   logic signed [dfa_pkg::EXP_WIDTH-1:0]   b_exp;
   modport source (output valid, action, raw_mant, a_mant, a_exp, b_mant, b_exp,
                   input ready);
   modport sink (input valid, action, raw_mant, a_mant, a_exp, b_mant, b_exp,
                 output ready);
endinterface

interface dfa_rsp_if #(parameter int MANT_WIDTH = dfa_pkg::MANT_WIDTH_DEF);
   logic                                   valid;
   logic                                   ready;
   logic signed [MANT_WIDTH-1:0]           r_mant;
   logic signed [dfa_pkg::EXP_WIDTH-1:0]   r_exp;
   logic [dfa_pkg::STATUS_WIDTH-1:0]       status;
   modport source (output valid, r_mant, r_exp, status, input ready);
   modport sink (input valid, r_mant, r_exp, status, output ready);
endinterface

### src/dfa_divider.sv
// bit-serial restoring divider, one quotient bit per cycle
module dfa_divider #(
   parameter int DVD_W = 64,
   parameter int DVS_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   import dfa_pkg::*;

   localparam int CNT_W = $clog2(DVD_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             fits;

   // trial subtract of the partial remainder
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = trial >= {1'b0, dvs_ff};
   end

   // next state of the shift registers
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[DVD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

### src/decimal_float_alu.sv
// decimal float alu top level
//
// Decimal float ALU: make, mul, div, add, sub and sqrt on numbers of the form
// mantissa * 10^exponent. One request is taken at a time; req ready is low from
// acceptance until the result has been moved into the response register. After
// idle and load, add/sub align by one decade per digit of exponent gap (at most
// 14), div scales in x10 steps and then runs the bit-serial quotient, and sqrt
// scales in x100 steps and then finds the root bit by bit. Normalization then
// makes one check per decimal digit rounded off plus a final check, each made
// with a divide by ten that handles 16 bits a cycle; a zero result skips it.
// Finish waits while an unread response blocks the response register. The
// response waits in its own register so the next request may be accepted
// while it is still unread.
`include "assert_macros.svh"

module decimal_float_alu #(
   parameter int MANT_WIDTH = dfa_pkg::MANT_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   dfa_req_if.sink   req_if,
   dfa_rsp_if.source rsp_if
);
   import dfa_pkg::*;

   localparam int MW    = MANT_WIDTH;
   localparam int MAG_W = MW + 48;
   localparam int ACC_W = MAG_W + 1;
   localparam int GAP_W = $clog2(ADD_MAX_GAP + 1);
   localparam int SQ_W  = 2 * SQRT_BITS;

   localparam int TEN_CHUNK  = 16;
   localparam int TEN_PART_W = TEN_CHUNK + 4;
   localparam int TEN_CHUNKS = (MAG_W + TEN_CHUNK - 1) / TEN_CHUNK;
   localparam int TEN_W      = TEN_CHUNKS * TEN_CHUNK;
   localparam int TEN_CNT_W  = $clog2(TEN_CHUNKS + 1);
   localparam int TEN_SHIFT  = 23;
   // ceil(2^23 / 10), exact for partial dividends below 2^22
   localparam logic [TEN_PART_W-1:0] TEN_RECIP = TEN_PART_W'(838861);

   localparam logic [MAG_W-1:0] MANT_LIMIT = MAG_W'((64'd1 << (MW - 1)) - 64'd1);
   localparam logic [MAG_W-1:0] DIV_REACH  = MAG_W'(64'd1 << DIV_REACH_LOG);
   localparam logic [MAG_W-1:0] SQ_REACH   = MAG_W'(64'd1 << SQRT_REACH_LOG);
   localparam logic signed [EXP_INT_W-1:0] EXP_MAX = EXP_INT_W'(32767);
   localparam logic signed [EXP_INT_W-1:0] EXP_MIN = -EXP_INT_W'(32768);

   // captured request
   logic [ACTION_WIDTH-1:0]       action_ff;
   logic signed [RAW_WIDTH-1:0]   raw_ff;
   logic signed [MW-1:0]          am_ff, bm_ff;
   logic signed [EXP_WIDTH-1:0]   ae_ff, be_ff;

   // working registers
   state_type                     state_ff, state_in;
   logic [MAG_W-1:0]              mag_ff, mag_in;
   logic                          neg_ff, neg_in;
   logic signed [EXP_INT_W-1:0]   exp_ff, exp_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [ACC_W-1:0]       oth_ff, oth_in;
   logic [GAP_W-1:0]              gap_ff, gap_in;
   logic [MW-1:0]                 bdiv_ff, bdiv_in;
   logic [SQRT_BITS-1:0]          sq_y_ff, sq_y_in;
   logic [SQRT_BITS-1:0]          sq_bit_ff, sq_bit_in;
   status_type                    status_ff, status_in;

   // divide by ten for rounding
   logic [TEN_W-1:0]              ten_work_ff, ten_work_in;
   logic [3:0]                    ten_rem_ff, ten_rem_in;
   logic [TEN_CNT_W-1:0]          ten_cnt_ff, ten_cnt_in;
   logic [TEN_PART_W-1:0]         ten_part, ten_back;
   logic [2*TEN_PART_W-1:0]       ten_prod;
   logic [TEN_CHUNK-1:0]          ten_q;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [MW-1:0]          rmant_ff, rmant_in;
   logic signed [EXP_WIDTH-1:0]   rexp_ff, rexp_in;
   status_type                    rstat_ff, rstat_in;

   // load-stage helpers
   logic [MW-1:0]                 am_mag, bm_mag;
   logic [RAW_WIDTH-1:0]          raw_mag;
   logic [2*MW-1:0]               prod;
   logic signed [ACC_W-1:0]       am_s, bm_s, hi_m, lo_m;
   logic signed [EXP_WIDTH-1:0]   hi_e, lo_e;
   logic signed [EXP_INT_W-1:0]   gap;
   logic                          gap_big;
   logic [SQRT_BITS-1:0]          sq_t;
   logic [SQ_W-1:0]               sq_tt;
   logic                          req_fire, rsp_free;

   // quotient divider
   logic                          div_start, div_done;
   logic [MAG_W-1:0]              div_dividend, div_quo;
   logic [MW-1:0]                 div_divisor;
   logic                          norm_take;

   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   // request capture
   always_ff @(posedge clock) begin
      if (req_fire) begin
         action_ff <= req_if.action;
         raw_ff    <= req_if.raw_mant;
         am_ff     <= req_if.a_mant;
         ae_ff     <= req_if.a_exp;
         bm_ff     <= req_if.b_mant;
         be_ff     <= req_if.b_exp;
      end
   end

   // operand decode
   always_comb begin
      am_mag  = am_ff[MW-1] ? MW'(-am_ff) : MW'(am_ff);
      bm_mag  = bm_ff[MW-1] ? MW'(-bm_ff) : MW'(bm_ff);
      raw_mag = raw_ff[RAW_WIDTH-1] ? RAW_WIDTH'(-raw_ff) : RAW_WIDTH'(raw_ff);
      prod    = (2*MW)'(am_mag) * (2*MW)'(bm_mag);
      am_s    = ACC_W'(am_ff);
      bm_s    = (action_type'(action_ff) == ACT_SUB) ? -ACC_W'(bm_ff) : ACC_W'(bm_ff);
      if (ae_ff < be_ff) begin
         hi_m = bm_s;
         hi_e = be_ff;
         lo_m = am_s;
         lo_e = ae_ff;
      end else begin
         hi_m = am_s;
         hi_e = ae_ff;
         lo_m = bm_s;
         lo_e = be_ff;
      end
      gap     = EXP_INT_W'(hi_e) - EXP_INT_W'(lo_e);
      gap_big = gap > EXP_INT_W'(ADD_MAX_GAP);
      sq_t    = sq_y_ff | sq_bit_ff;
      sq_tt   = SQ_W'(sq_t) * SQ_W'(sq_t);
   end

   // divider operands for the quotient
   assign div_dividend = mag_ff;
   assign div_divisor  = bdiv_ff;
   assign div_start    = (state_ff == ST_DIV_SCALE) && (mag_ff >= DIV_REACH);

   // one chunk of the divide by ten: reciprocal multiply of the partial dividend
   always_comb begin
      ten_part  = {ten_rem_ff, ten_work_ff[TEN_W-1 -: TEN_CHUNK]};
      ten_prod  = (2*TEN_PART_W)'(ten_part) * (2*TEN_PART_W)'(TEN_RECIP);
      ten_q     = ten_prod[TEN_SHIFT +: TEN_CHUNK];
      ten_back  = ten_part - TEN_PART_W'(ten_q) * TEN_PART_W'(RADIX);
      norm_take = (mag_ff > MANT_LIMIT) || (ten_rem_ff == 4'(ROUND_BIAS));
   end

   dfa_divider #(
      .DVD_W (MAG_W),
      .DVS_W (MW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .quotient  (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:       if (req_if.valid) state_in = ST_LOAD;
         ST_LOAD: begin
            unique case (action_type'(action_ff))
               ACT_DIV:
                  state_in = (bm_ff == '0 || am_ff == '0) ? ST_NORM_START : ST_DIV_SCALE;
               ACT_ADD, ACT_SUB:
                  state_in = gap_big ? ST_NORM_START : ST_ADD_SCALE;
               ACT_SQRT:
                  state_in = am_ff[MW-1] ? ST_NORM_START : ST_SQ_SCALE;
               default:
                  state_in = ST_NORM_START;
            endcase
         end
         ST_ADD_SCALE:  if (gap_ff == '0) state_in = ST_ADD_SUM;
         ST_ADD_SUM:    state_in = ST_ADD_MAG;
         ST_ADD_MAG:    state_in = ST_NORM_START;
         ST_DIV_SCALE:  if (mag_ff >= DIV_REACH) state_in = ST_DIV_WAIT;
         ST_DIV_WAIT:   if (div_done) state_in = ST_NORM_START;
         ST_SQ_SCALE:   if (mag_ff == '0 || mag_ff >= SQ_REACH) state_in = ST_SQ_ODD;
         ST_SQ_ODD:     state_in = ST_SQ_ITER;
         ST_SQ_ITER:    if (sq_bit_ff[0]) state_in = ST_SQ_HALF;
         ST_SQ_HALF:    state_in = ST_NORM_START;
         ST_NORM_START: state_in = (mag_ff == '0) ? ST_FINISH : ST_NORM_WAIT;
         ST_NORM_WAIT: begin
            if (ten_cnt_ff == '0) state_in = norm_take ? ST_NORM_START : ST_FINISH;
         end
         ST_FINISH:     if (rsp_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // datapath updates per state
   always_comb begin
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      exp_in      = exp_ff;
      acc_in      = acc_ff;
      oth_in      = oth_ff;
      gap_in      = gap_ff;
      bdiv_in     = bdiv_ff;
      sq_y_in     = sq_y_ff;
      sq_bit_in   = sq_bit_ff;
      status_in   = status_ff;
      ten_work_in = ten_work_ff;
      ten_rem_in  = ten_rem_ff;
      ten_cnt_in  = ten_cnt_ff;
      case (state_ff)
         ST_LOAD: begin
            status_in = STAT_OK;
            neg_in    = 1'b0;
            mag_in    = '0;
            exp_in    = '0;
            case (action_type'(action_ff))
               ACT_MAKE: begin
                  mag_in = MAG_W'(raw_mag);
                  neg_in = raw_ff[RAW_WIDTH-1];
                  exp_in = EXP_INT_W'(ae_ff);
               end
               ACT_MUL: begin
                  mag_in = MAG_W'(prod);
                  neg_in = am_ff[MW-1] ^ bm_ff[MW-1];
                  exp_in = EXP_INT_W'(ae_ff) + EXP_INT_W'(be_ff);
               end
               ACT_DIV: begin
                  if (bm_ff == '0) begin
                     status_in = STAT_DIV_ZERO;
                  end else if (am_ff != '0) begin
                     mag_in  = MAG_W'(am_mag);
                     neg_in  = am_ff[MW-1] ^ bm_ff[MW-1];
                     exp_in  = EXP_INT_W'(ae_ff) - EXP_INT_W'(be_ff);
                     bdiv_in = bm_mag;
                  end
               end
               ACT_ADD, ACT_SUB: begin
                  if (gap_big) begin
                     mag_in = MAG_W'(hi_m[ACC_W-1] ? -hi_m : hi_m);
                     neg_in = hi_m[ACC_W-1];
                     exp_in = EXP_INT_W'(hi_e);
                  end else begin
                     acc_in = hi_m;
                     oth_in = lo_m;
                     exp_in = EXP_INT_W'(lo_e);
                     gap_in = gap[GAP_W-1:0];
                  end
               end
               ACT_SQRT: begin
                  if (am_ff[MW-1]) begin
                     status_in = STAT_NEG_SQRT;
                  end else begin
                     mag_in = MAG_W'(am_mag);
                     exp_in = EXP_INT_W'(ae_ff);
                  end
               end
               default: begin
                  mag_in = '0;
               end
            endcase
         end
         // align the larger-exponent operand, one decade a cycle
         ST_ADD_SCALE: begin
            if (gap_ff != '0) begin
               acc_in = (acc_ff <<< 3) + (acc_ff <<< 1);
               gap_in = gap_ff - 1'b1;
            end
         end
         ST_ADD_SUM: acc_in = acc_ff + oth_ff;
         ST_ADD_MAG: begin
            mag_in = MAG_W'(acc_ff[ACC_W-1] ? -acc_ff : acc_ff);
            neg_in = acc_ff[ACC_W-1];
         end
         // grow the dividend to at least 2^24
         ST_DIV_SCALE: begin
            if (mag_ff < DIV_REACH) begin
               mag_in = (mag_ff << 3) + (mag_ff << 1);
               exp_in = exp_ff - 1'b1;
            end
         end
         ST_DIV_WAIT: if (div_done) mag_in = div_quo;
         // grow the radicand by 100 until 2^20
         ST_SQ_SCALE: begin
            if (mag_ff != '0 && mag_ff < SQ_REACH) begin
               mag_in = (mag_ff << 6) + (mag_ff << 5) + (mag_ff << 2);
               exp_in = exp_ff - EXP_INT_W'(2);
            end
         end
         // make the exponent even
         ST_SQ_ODD: begin
            if (exp_ff[0]) begin
               mag_in = (mag_ff << 3) + (mag_ff << 1);
               exp_in = exp_ff - 1'b1;
            end
            sq_y_in   = '0;
            sq_bit_in = SQRT_BITS'(1) << (SQRT_BITS - 1);
         end
         // one root bit a cycle
         ST_SQ_ITER: begin
            if (MAG_W'(sq_tt) <= mag_ff) sq_y_in = sq_t;
            sq_bit_in = sq_bit_ff >> 1;
         end
         ST_SQ_HALF: begin
            mag_in = MAG_W'(sq_y_ff);
            exp_in = exp_ff >>> 1;
         end
         // start a divide by ten of the rounded magnitude
         ST_NORM_START: begin
            ten_work_in = TEN_W'(mag_ff + MAG_W'(ROUND_BIAS));
            ten_rem_in  = '0;
            ten_cnt_in  = TEN_CNT_W'(TEN_CHUNKS);
         end
         // one chunk a cycle, then round off one decimal digit if the check asks for it
         ST_NORM_WAIT: begin
            if (ten_cnt_ff != '0) begin
               ten_work_in = {ten_work_ff[TEN_W-TEN_CHUNK-1:0], ten_q};
               ten_rem_in  = ten_back[3:0];
               ten_cnt_in  = ten_cnt_ff - 1'b1;
            end else if (norm_take) begin
               mag_in = ten_work_ff[MAG_W-1:0];
               exp_in = exp_ff + 1'b1;
            end
         end
         default: begin
            mag_in = mag_ff;
         end
      endcase
   end

   // response register with exponent saturation
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rmant_in     = rmant_ff;
      rexp_in      = rexp_ff;
      rstat_in     = rstat_ff;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in = 1'b1;
         rmant_in     = neg_ff ? -mag_ff[MW-1:0] : mag_ff[MW-1:0];
         rstat_in     = status_ff;
         if (exp_ff > EXP_MAX) begin
            rexp_in  = EXP_WIDTH'(EXP_MAX);
            rstat_in = STAT_EXP_OVF;
         end else if (exp_ff < EXP_MIN) begin
            rexp_in  = EXP_WIDTH'(EXP_MIN);
            rstat_in = STAT_EXP_OVF;
         end else begin
            rexp_in = exp_ff[EXP_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sq_bit_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sq_bit_ff    <= sq_bit_in;
      end
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      oth_ff      <= oth_in;
      gap_ff      <= gap_in;
      bdiv_ff     <= bdiv_in;
      sq_y_ff     <= sq_y_in;
      status_ff   <= status_in;
      ten_work_ff <= ten_work_in;
      ten_rem_ff  <= ten_rem_in;
      ten_cnt_ff  <= ten_cnt_in;
      rmant_ff    <= rmant_in;
      rexp_ff     <= rexp_in;
      rstat_ff    <= rstat_in;
   end

   // ports
   assign req_if.ready  = state_ff == ST_IDLE;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.r_mant = rmant_ff;
   assign rsp_if.r_exp  = rexp_ff;
   assign rsp_if.status = rstat_ff;

   // checks
   `DFA_ASSERT_ALWAYS(a_sq_bit_onehot, clock, reset, $onehot0(sq_bit_ff), "root bit not one-hot")
   `DFA_ASSERT_IMPL(a_div_done_state, clock, reset, div_done, state_ff == ST_DIV_WAIT, "divider done outside its wait state")
   `DFA_ASSERT_NEXT(a_busy_after_req, clock, reset, req_fire, !req_if.ready, "ready right after a request")
   `DFA_ASSERT_IMPL(a_neg_sqrt_zero, clock, reset, rsp_if.valid && rsp_if.status == STAT_NEG_SQRT, rsp_if.r_mant == '0 && rsp_if.r_exp == '0, "negative root result not zero")
endmodule

### test/tb_decimal_float_alu.sv
// self-checking testbench for the decimal float alu
`timescale 1ns / 100ps

module tb_decimal_float_alu;
   import dfa_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int DRAIN_CYCLES = 1500;
   localparam int RANDOM_REQUESTS = 550;

   typedef struct {
      logic [ACTION_WIDTH-1:0] action;
      logic signed [31:0]      raw_mant;
      logic signed [15:0]      a_mant;
      logic signed [15:0]      a_exp;
      logic signed [15:0]      b_mant;
      logic signed [15:0]      b_exp;
   } alu_request_t;

   typedef struct {
      logic signed [15:0] mant;
      logic signed [15:0] expo;
      status_type         stat;
   } alu_result_t;

   // computes the expected result of each request and checks responses in order
   class alu_scoreboard;
      alu_result_t pending_results[$];
      int          fail_count = 0;

      // round the magnitude to the mantissa limit, strip trailing zeros and saturate the exponent
      function alu_result_t round_result(longint mag, bit neg, longint e, status_type st);
         alu_result_t r;
         while (mag != 0 && (mag > 32767 || mag % 10 == 0)) begin
            mag = (mag + 5) / 10;
            e++;
         end
         if (e > 32767) begin
            e = 32767;
            st = STAT_EXP_OVF;
         end
         if (e < -32768) begin
            e = -32768;
            st = STAT_EXP_OVF;
         end
         r.mant = neg ? -mag : mag;
         r.expo = e;
         r.stat = st;
         return r;
      endfunction

      function alu_result_t fixed_result(status_type st);
         alu_result_t r;
         r.mant = 0;
         r.expo = 0;
         r.stat = st;
         return r;
      endfunction

      function longint magnitude(longint v);
         return v < 0 ? -v : v;
      endfunction

      // aligned sum; a gap over the limit keeps the operand with the larger exponent
      function alu_result_t sum_result(longint am, longint ae, longint bm, longint be);
         longint t;
         longint s;
         if (ae < be) begin
            t = am; am = bm; bm = t;
            t = ae; ae = be; be = t;
         end
         if (ae - be > ADD_MAX_GAP)
            return round_result(magnitude(am), am < 0, ae, STAT_OK);
         s = am;
         for (longint i = 0; i < ae - be; i++)
            s *= 10;
         s += bm;
         return round_result(magnitude(s), s < 0, be, STAT_OK);
      endfunction

      function longint floor_root(longint x);
         longint y;
         longint t;
         y = 0;
         for (int b = 15; b >= 0; b--) begin
            t = y | (longint'(1) << b);
            if (t * t <= x)
               y = t;
         end
         return y;
      endfunction

      function alu_result_t predict_result(alu_request_t q);
         longint am, ae, bm, be, m, e;
         am = q.a_mant;
         ae = q.a_exp;
         bm = q.b_mant;
         be = q.b_exp;
         case (q.action)
            ACT_MAKE: begin
               m = q.raw_mant;
               return round_result(magnitude(m), m < 0, ae, STAT_OK);
            end
            ACT_MUL:
               return round_result(magnitude(am) * magnitude(bm), (am < 0) != (bm < 0),
                                   ae + be, STAT_OK);
            ACT_DIV: begin
               if (bm == 0) return fixed_result(STAT_DIV_ZERO);
               if (am == 0) return fixed_result(STAT_OK);
               m = magnitude(am);
               e = 0;
               while (m < (longint'(1) << DIV_REACH_LOG)) begin
                  m *= 10;
                  e--;
               end
               return round_result(m / magnitude(bm), (am < 0) != (bm < 0),
                                   e + ae - be, STAT_OK);
            end
            ACT_ADD: return sum_result(am, ae, bm, be);
            ACT_SUB: return sum_result(am, ae, -bm, be);
            ACT_SQRT: begin
               if (am < 0) return fixed_result(STAT_NEG_SQRT);
               m = am;
               e = ae;
               while (m != 0 && m < (longint'(1) << SQRT_REACH_LOG)) begin
                  m *= 100;
                  e -= 2;
               end
               if (e[0]) begin
                  m *= 10;
                  e--;
               end
               return round_result(floor_root(m), 1'b0, e / 2, STAT_OK);
            end
            default: return fixed_result(STAT_OK);
         endcase
      endfunction

      function void note_request(alu_request_t q);
         pending_results.push_back(predict_result(q));
      endfunction

      function void check_response(logic signed [15:0] mant, logic signed [15:0] expo,
                                   logic [1:0] stat);
         alu_result_t x;
         if (pending_results.size() == 0) begin
            $error("unexpected response mant %0d exp %0d status %0d", mant, expo, stat);
            fail_count++;
            return;
         end
         x = pending_results.pop_front();
         if (mant !== x.mant) begin
            $error("r_mant: expected %0d actual %0d", x.mant, mant);
            fail_count++;
         end
         if (expo !== x.expo) begin
            $error("r_exp: expected %0d actual %0d", x.expo, expo);
            fail_count++;
         end
         if (stat !== x.stat) begin
            $error("status: expected %0d actual %0d", x.stat, stat);
            fail_count++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   sender_idle_pct = 21;
   int   receiver_idle_pct = 63;
   alu_scoreboard scoreboard = new();

   dfa_req_if req_if ();
   dfa_rsp_if rsp_if ();

   decimal_float_alu dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_if),
      .rsp_if(rsp_if)
   );

   // clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("decimal_float_alu verification failed");
         $finish;
      end
   end

   // response ready with random stalls
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // response checking
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         scoreboard.check_response(rsp_if.r_mant, rsp_if.r_exp, rsp_if.status);
   end

   // drive one request, with random idle cycles ahead of it
   task automatic send_request(alu_request_t q);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.action   <= q.action;
      req_if.raw_mant <= q.raw_mant;
      req_if.a_mant   <= q.a_mant;
      req_if.a_exp    <= q.a_exp;
      req_if.b_mant   <= q.b_mant;
      req_if.b_exp    <= q.b_exp;
      do
         @(posedge clock);
      while (!req_if.ready);
      scoreboard.note_request(q);
   endtask

   task automatic send_fields(logic [2:0] act, logic signed [31:0] raw,
                              logic signed [15:0] am, logic signed [15:0] ae,
                              logic signed [15:0] bm, logic signed [15:0] be);
      alu_request_t q;
      q.action = act;
      q.raw_mant = raw;
      q.a_mant = am;
      q.a_exp = ae;
      q.b_mant = bm;
      q.b_exp = be;
      send_request(q);
   endtask

   function automatic logic signed [15:0] random_exp();
      if ($urandom_range(3) == 0)
         return 16'($urandom);
      return 16'($signed($urandom_range(60)) - 30);
   endfunction

   function automatic logic signed [15:0] random_mant();
      case ($urandom_range(3))
         0: return 16'($signed($urandom_range(200)) - 100);
         1: return 16'($signed($urandom_range(20)) * 10 - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   // random requests, mostly valid actions with a few unused codes
   task automatic send_random(int count);
      alu_request_t q;
      for (int i = 0; i < count; i++) begin
         q.action = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
         case ($urandom_range(2))
            0: q.raw_mant = $signed($urandom_range(2000)) - 1000;
            1: q.raw_mant = $signed($urandom_range(200000)) * 100 - 10000000;
            default: q.raw_mant = $urandom;
         endcase
         q.a_mant = random_mant();
         q.b_mant = random_mant();
         q.a_exp = random_exp();
         q.b_exp = ($urandom_range(1) == 0) ?
                   16'(q.a_exp + $signed($urandom_range(34)) - 17) : random_exp();
         send_request(q);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.action = '0;
      req_if.raw_mant = '0;
      req_if.a_mant = '0;
      req_if.a_exp = '0;
      req_if.b_mant = '0;
      req_if.b_exp = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed corner cases
      send_fields(ACT_MAKE, 32'sd2147483647, 0, 0, 0, 0);
      send_fields(ACT_MAKE, -32'sd2147483647, 0, -16'sd32768, 0, 0);
      send_fields(ACT_MAKE, 32'h80000000, 0, 16'sd32767, 0, 0);
      send_fields(ACT_MAKE, 0, 0, 16'sd123, 0, 0);
      send_fields(ACT_MAKE, 32'sd1000, 0, -16'sd5, 0, 0);
      send_fields(ACT_MUL, 0, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
      send_fields(ACT_MUL, 0, 16'h8000, -16'sd32768, 16'h8000, -16'sd32768);
      send_fields(ACT_MUL, 0, -16'sd3, 2, 16'sd7, -1);
      send_fields(ACT_DIV, 0, 16'sd5, 0, 16'sd0, 0);
      send_fields(ACT_DIV, 0, 16'sd0, 3, 16'sd7, 1);
      send_fields(ACT_DIV, 0, 16'h8000, 16'sd32767, 16'sd1, -16'sd32768);
      send_fields(ACT_DIV, 0, 16'sd1, 0, -16'sd32767, 0);
      send_fields(ACT_ADD, 0, 16'sd5, 0, -16'sd5, 0);
      send_fields(ACT_ADD, 0, 16'sd32767, 14, 16'sd32767, 0);
      send_fields(ACT_ADD, 0, 16'sd12, 0, 16'sd99, 15);
      send_fields(ACT_ADD, 0, 16'h8000, 16'sd32767, 16'sd1, -16'sd32768);
      send_fields(ACT_SUB, 0, 16'sd7, 3, 16'h8000, 3);
      send_fields(ACT_SUB, 0, 16'sd1, -20, 16'sd4, 0);
      send_fields(ACT_SQRT, 0, -16'sd1, 0, 0, 0);
      send_fields(ACT_SQRT, 0, 16'sd0, 7, 0, 0);
      send_fields(ACT_SQRT, 0, 16'sd32767, -16'sd32767, 0, 0);
      send_fields(ACT_SQRT, 0, 16'sd2, 16'sd32767, 0, 0);
      send_fields(3'd6, 32'sd5, 16'sd1, 1, 1, 1);
      send_fields(3'd7, -32'sd1, -16'sd1, -1, -1, -1);

      // random traffic in three idle phases
      send_random(RANDOM_REQUESTS / 3);
      sender_idle_pct = 63;
      receiver_idle_pct = 21;
      send_random(RANDOM_REQUESTS / 3);
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      send_random(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));
      req_if.valid <= 1'b0;

      while (scoreboard.pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.fail_count == 0)
         $display("decimal_float_alu verification clean");
      else
         $display("decimal_float_alu verification failed");
      $finish;
   end
endmodule
